/* rtl/v3a_pkg.sv */
// Package for the three-component vector unit: widths, command and status codes,
// and the structs passed between the lanes, the root and divide pipes and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package v3a_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * W;
  localparam int RW   = W + 1;
  localparam int SW   = 2 * RW;
  localparam int DVW  = W + F;
  localparam int SIDE_DEPTH = RW + DVW + 1;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_SCALE = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_DOT   = 4'd4,
    CMD_CROSS = 4'd5,
    CMD_MAG   = 4'd6,
    CMD_NORM  = 4'd7,
    CMD_EQ    = 4'd8,
    CMD_NE    = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_OVF  = 2'd2
  } stat_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [2:0][W-1:0]  a;
    logic [2:0][W-1:0]  b;
    logic [W-1:0]       fac;
  } in_t;

  typedef struct packed {
    logic signed [PW-1:0] prod;
    logic signed [W-1:0]  val;
    logic                 ovf;
    logic [DVW-1:0]       dvd;
    logic                 neg;
  } lane_out_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [2:0][W-1:0]   res;
    logic [2:0]          ovf;
    logic [2:0][DVW-1:0] dvd;
    logic [2:0]          neg;
    logic [W-1:0]        scal;
    logic                scal_ovf;
    logic                cmp;
    logic                fac_zero;
    logic [RW-1:0]       fac_abs;
    logic [SW-1:0]       sumsq;
    logic [RW-1:0]       m;
  } side_t;

  typedef struct packed {
    logic [2:0][W-1:0] res;
    logic [W-1:0]      scal;
    logic              cmp;
    stat_t             st;
  } out_t;

endpackage
`default_nettype wire

/* rtl/v3a_chan_if.sv */
// Channel interfaces of the vector unit: operand word in, result word out.
// Depends on v3a_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface v3a_in_if import v3a_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [3:0]          cmd;
  logic signed [W-1:0] a_x;
  logic signed [W-1:0] a_y;
  logic signed [W-1:0] a_z;
  logic signed [W-1:0] b_x;
  logic signed [W-1:0] b_y;
  logic signed [W-1:0] b_z;
  logic signed [W-1:0] factor;

  modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, factor, input ready);
  modport sink   (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, factor, output ready);
endinterface

interface v3a_out_if import v3a_pkg::*; ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] res_x;
  logic signed [W-1:0] res_y;
  logic signed [W-1:0] res_z;
  logic signed [W-1:0] res_scalar;
  logic                compare_true;
  logic [1:0]          status;

  modport source (output valid, res_x, res_y, res_z, res_scalar, compare_true, status,
                  input ready);
  modport sink   (input valid, res_x, res_y, res_z, res_scalar, compare_true, status,
                  output ready);
endinterface
`default_nettype wire

/* rtl/v3a_lane.sv */
// One component lane: registered products, then add/sub/scale/cross with saturation
// and the dividend for the divide pipe. Depends on v3a_pkg.
`timescale 1ns / 1ps
`default_nettype none
module v3a_lane import v3a_pkg::*; (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire cmd_t                cmd,
  input  wire logic signed [W-1:0] a_i,
  input  wire logic signed [W-1:0] b_i,
  input  wire logic signed [W-1:0] a_j,
  input  wire logic signed [W-1:0] b_j,
  input  wire logic signed [W-1:0] a_k,
  input  wire logic signed [W-1:0] b_k,
  input  wire logic signed [W-1:0] fac,
  output lane_out_t                res
);

  logic signed [W-1:0]  op_a, op_b;
  logic signed [PW-1:0] pa_r, pb_r;
  logic signed [W-1:0]  a_r, b_r, fac_r;
  cmd_t                 cmd_r;
  logic signed [PW:0]   wide, diff;
  logic [W-1:0]         mag;

  always_comb begin
    op_a = (cmd == CMD_CROSS) ? a_j : a_i;
    unique case (cmd)
      CMD_CROSS:          op_b = b_k;
      CMD_SCALE:          op_b = fac;
      CMD_MAG, CMD_NORM:  op_b = a_i;
      default:            op_b = b_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= op_a * op_b;
      pb_r  <= a_k * b_j;
      a_r   <= a_i;
      b_r   <= b_i;
      fac_r <= fac;
      cmd_r <= cmd;
    end
  end

  always_comb begin
    diff = (PW+1)'(pa_r) - (PW+1)'(pb_r);
    unique case (cmd_r)
      CMD_ADD:   wide = (PW+1)'(a_r) + (PW+1)'(b_r);
      CMD_SUB:   wide = (PW+1)'(a_r) - (PW+1)'(b_r);
      CMD_SCALE: wide = (PW+1)'(pa_r >>> F);
      CMD_CROSS: wide = diff >>> F;
      default:   wide = '0;
    endcase
    res.prod = pa_r;
    res.ovf  = (wide > (PW+1)'(VMAX)) || (wide < (PW+1)'(VMIN));
    if (wide > (PW+1)'(VMAX))      res.val = VMAX;
    else if (wide < (PW+1)'(VMIN)) res.val = VMIN;
    else                           res.val = wide[W-1:0];
    mag     = a_r[W-1] ? W'(-a_r) : W'(a_r);
    res.dvd = {mag, {F{1'b0}}};
    res.neg = a_r[W-1] ^ ((cmd_r == CMD_DIV) && fac_r[W-1]);
  end

endmodule
`default_nettype wire

/* rtl/v3a_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on v3a_pkg.
`timescale 1ns / 1ps
`default_nettype none
module v3a_sqrt import v3a_pkg::*; (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [SW-1:0] s_in,
  output logic      [RW-1:0] root
);

  localparam int RMW = RW + 3;

  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [SW-1:0]  s_r    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic [RMW-1:0] rem_i, rem_sh, trial;
    logic [RW-1:0]  root_i;
    logic [SW-1:0]  s_i;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign s_i    = s_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign s_i    = s_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_i[RMW-3:0], s_i[SW-1 -: 2]};
      trial  = RMW'({root_i, 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_i[RW-2:0], ge};
        s_r[k]    <= {s_i[SW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RW-1];

endmodule
`default_nettype wire

/* rtl/v3a_div.sv */
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on v3a_pkg.
`timescale 1ns / 1ps
`default_nettype none
module v3a_div import v3a_pkg::*; (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [DVW-1:0] dvd,
  input  wire logic [RW-1:0]  dvs,
  output logic      [DVW-1:0] quo
);

  logic [RW-1:0]  rem_r [DVW];
  logic [DVW-1:0] n_r   [DVW];
  logic [DVW-1:0] q_r   [DVW];
  logic [RW-1:0]  d_r   [DVW];

  for (genvar k = 0; k < DVW; k++) begin : g_stg
    logic [RW-1:0]  rem_i, d_i;
    logic [DVW-1:0] n_i, q_i;
    logic [RW:0]    rem_sh, rem_sub;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign n_i   = dvd;
      assign q_i   = '0;
      assign d_i   = dvs;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign n_i   = n_r[k-1];
      assign q_i   = q_r[k-1];
      assign d_i   = d_r[k-1];
    end

    always_comb begin
      rem_sh  = {rem_i, n_i[DVW-1]};
      ge      = (rem_sh >= {1'b0, d_i});
      rem_sub = rem_sh - {1'b0, d_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
        n_r[k]   <= {n_i[DVW-2:0], 1'b0};
        q_r[k]   <= {q_i[DVW-2:0], ge};
        d_r[k]   <= d_i;
      end
    end
  end

  assign quo = q_r[DVW-1];

endmodule
`default_nettype wire

/* rtl/vector3_arith_unit.sv */
// Top level of the vector unit: input register, three lanes, square root and divide
// pipes, sideband delay line and the merging output register.
// Depends on v3a_pkg, v3a_chan_if, v3a_lane, v3a_sqrt, v3a_div.
//
//   port     dir  carries
//   in_ch    in   cmd, vectors a and b, factor
//   out_ch   out  result vector, scalar, compare flag, status
//
// One word enters per cycle while the pipe is not held; each word passes through
// the bit-per-stage root pipe followed by the divide pipe.
// Reset is synchronous and clears only the valid bits.
// The whole pipe holds when the output register is full and not taken;
// in_ch.ready is low exactly then.
`timescale 1ns / 1ps
`default_nettype none
module vector3_arith_unit import v3a_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  v3a_in_if.sink     in_ch,
  v3a_out_if.source  out_ch
);

  logic        en;
  in_t         in_r, in2_r;
  logic        in_v_r, p_v_r, out_v_r;
  logic        vld_r [SIDE_DEPTH];
  side_t       side_r [SIDE_DEPTH];
  side_t       side_nxt, sd, side_m;
  lane_out_t   lane [3];
  logic [RW-1:0]  sq_q;
  logic [DVW-1:0] quo [3];
  logic signed [PW+1:0] dsum, dsh;
  out_t        out_r, out_nxt;
  logic        ovf, dz;
  logic [DVW-1:0] half;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      in_r.cmd  <= cmd_t'(in_ch.cmd);
      in_r.a    <= {in_ch.a_z, in_ch.a_y, in_ch.a_x};
      in_r.b    <= {in_ch.b_z, in_ch.b_y, in_ch.b_x};
      in_r.fac  <= in_ch.factor;
      in2_r     <= in_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane u_lane (
      .clk (clk),
      .en  (en),
      .cmd (in_r.cmd),
      .a_i (signed'(in_r.a[i])),
      .b_i (signed'(in_r.b[i])),
      .a_j (signed'(in_r.a[(i+1)%3])),
      .b_j (signed'(in_r.b[(i+1)%3])),
      .a_k (signed'(in_r.a[(i+2)%3])),
      .b_k (signed'(in_r.b[(i+2)%3])),
      .fac (signed'(in_r.fac)),
      .res (lane[i])
    );
  end

  always_comb begin
    dsum = (PW+2)'(lane[0].prod) + (PW+2)'(lane[1].prod) + (PW+2)'(lane[2].prod);
    dsh  = dsum >>> F;
    side_nxt.cmd   = in2_r.cmd;
    side_nxt.sumsq = SW'(unsigned'(lane[0].prod)) + SW'(unsigned'(lane[1].prod))
                   + SW'(unsigned'(lane[2].prod));
    for (int i = 0; i < 3; i++) begin
      side_nxt.res[i] = lane[i].val;
      side_nxt.ovf[i] = lane[i].ovf;
      side_nxt.dvd[i] = lane[i].dvd;
      side_nxt.neg[i] = lane[i].neg;
    end
    side_nxt.scal_ovf = (dsh > (PW+2)'(VMAX)) || (dsh < (PW+2)'(VMIN));
    if (dsh > (PW+2)'(VMAX))      side_nxt.scal = VMAX;
    else if (dsh < (PW+2)'(VMIN)) side_nxt.scal = VMIN;
    else                          side_nxt.scal = dsh[W-1:0];
    side_nxt.cmp = (in2_r.a == in2_r.b) ? (in2_r.cmd == CMD_EQ) : (in2_r.cmd == CMD_NE);
    side_nxt.fac_zero = (in2_r.fac == '0);
    side_nxt.fac_abs  = in2_r.fac[W-1] ? RW'(-signed'(RW'(signed'(in2_r.fac))))
                                        : RW'(in2_r.fac);
    side_nxt.m = '0;
  end

  always_comb begin
    side_m   = side_r[RW];
    side_m.m = sq_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        side_r[k] <= (k == RW + 1) ? side_m : side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      p_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < SIDE_DEPTH; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      in_v_r   <= in_ch.valid;
      p_v_r    <= in_v_r;
      vld_r[0] <= p_v_r;
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_v_r  <= vld_r[SIDE_DEPTH-1];
    end
  end

  v3a_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .s_in (side_r[0].sumsq),
    .root (sq_q)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div u_div (
      .clk (clk),
      .en  (en),
      .dvd (side_r[RW].dvd[i]),
      .dvs ((side_r[RW].cmd == CMD_DIV) ? side_r[RW].fac_abs : sq_q),
      .quo (quo[i])
    );
  end

  always_comb begin
    sd      = side_r[SIDE_DEPTH-1];
    half    = DVW'(1) << (W-1);
    out_nxt = '0;
    ovf     = 1'b0;
    dz      = 1'b0;
    unique case (sd.cmd)
      CMD_ADD, CMD_SUB, CMD_SCALE, CMD_CROSS: begin
        out_nxt.res = sd.res;
        ovf         = |sd.ovf;
      end
      CMD_DIV, CMD_NORM: begin
        dz = (sd.cmd == CMD_DIV) ? sd.fac_zero : (sd.m == '0);
        if (!dz) begin
          for (int i = 0; i < 3; i++) begin
            if (sd.neg[i]) begin
              if (quo[i] > half) begin
                out_nxt.res[i] = VMIN;
                ovf            = 1'b1;
              end else begin
                out_nxt.res[i] = W'(-quo[i][W-1:0]);
              end
            end else if (quo[i] > DVW'(VMAX)) begin
              out_nxt.res[i] = VMAX;
              ovf            = 1'b1;
            end else begin
              out_nxt.res[i] = quo[i][W-1:0];
            end
          end
        end
      end
      CMD_DOT: begin
        out_nxt.scal = sd.scal;
        ovf          = sd.scal_ovf;
      end
      CMD_MAG: begin
        if (sd.m > RW'(VMAX)) begin
          out_nxt.scal = VMAX;
          ovf          = 1'b1;
        end else begin
          out_nxt.scal = sd.m[W-1:0];
        end
      end
      CMD_EQ, CMD_NE: out_nxt.cmp = sd.cmp;
      default: ;
    endcase
    priority if (dz) out_nxt.st = ST_DIVZ;
    else if (ovf)    out_nxt.st = ST_OVF;
    else             out_nxt.st = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.res_x        = out_r.res[0];
  assign out_ch.res_y        = out_r.res[1];
  assign out_ch.res_z        = out_r.res[2];
  assign out_ch.res_scalar   = out_r.scal;
  assign out_ch.compare_true = out_r.cmp;
  assign out_ch.status       = out_r.st;

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_DIVZ) |->
      (out_ch.res_x == '0 && out_ch.res_y == '0 && out_ch.res_z == '0))
    else $error("division error with nonzero vector");

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.compare_true) |->
      (out_ch.status == ST_OK && out_ch.res_scalar == '0 && out_ch.res_x == '0))
    else $error("compare word carries other results");

  a_scalar_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.res_scalar != '0) |->
      (out_ch.res_x == '0 && out_ch.res_y == '0 && out_ch.res_z == '0
       && out_ch.status != ST_DIVZ))
    else $error("scalar result with vector result");

endmodule
`default_nettype wire
